>>> src/cbs_pkg.sv
// Package for the cartridge bank switcher.
// Holds the configuration type, register indexes, item modes and decode constants.
// Depends on nothing.
package cbs_pkg;

    localparam int ROM_BYTES_DEF  = 32768;
    localparam int BANK_BYTES_DEF = 4096;
    localparam int RAM_BYTES_DEF  = 128;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    typedef enum logic [1:0] {
        REG_BANK_MODE = 2'd0,
        REG_SMALL_ROM = 2'd1,
        REG_XRAM_EN   = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BANK_NONE = 2'd0,
        BANK_F8   = 2'd1,
        BANK_F6   = 2'd2,
        BANK_F4   = 2'd3
    } t_bank_mode;

    typedef struct packed {
        t_bank_mode bank_mode;
        logic       small_rom;
        logic       xram_en;
    } t_cfg;

    localparam logic [11:0] MASK_4K   = 12'h0FFF;
    localparam logic [11:0] MASK_2K   = 12'h07FF;
    localparam logic [11:0] HOT_F8_LO = 12'hFF8;
    localparam logic [11:0] HOT_F8_HI = 12'hFF9;
    localparam logic [11:0] HOT_F6_LO = 12'hFF6;
    localparam logic [11:0] HOT_F4_LO = 12'hFF4;
    localparam logic [11:0] HOT_F4_HI = 12'hFFB;
    localparam logic [11:0] XRAM_RD_LO = 12'h080;
    localparam logic [11:0] XRAM_RD_HI = 12'h100;
    localparam logic [11:0] XRAM_WR_HI = 12'h080;
    localparam logic [6:0]  XRAM_MASK  = 7'h7F;

endpackage

>>> src/cbs_cfg_regs.sv
// Configuration registers of the cartridge bank switcher behind an APB-style port.
// Depends on cbs_pkg for the register indexes and the configuration struct.
module cbs_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbs_pkg::CFG_AW-1:0]  paddr,
    input  logic [cbs_pkg::CFG_DW-1:0]  pwdata,
    output logic [cbs_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output cbs_pkg::t_cfg               o_cfg
);
    import cbs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{bank_mode: BANK_NONE, small_rom: 1'b0, xram_en: 1'b0};
        end else if (w_wr) begin
            case (w_idx)
                REG_BANK_MODE: r_cfg.bank_mode <= t_bank_mode'(pwdata[1:0]);
                REG_SMALL_ROM: r_cfg.small_rom <= pwdata[0];
                REG_XRAM_EN:   r_cfg.xram_en   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BANK_MODE: prdata = {{(CFG_DW-2){1'b0}}, r_cfg.bank_mode};
            REG_SMALL_ROM: prdata = {{(CFG_DW-1){1'b0}}, r_cfg.small_rom};
            REG_XRAM_EN:   prdata = {{(CFG_DW-1){1'b0}}, r_cfg.xram_en};
            default:       prdata = '0;
        endcase
    end

endmodule

>>> src/cbs_rom.sv
// ROM image store of the cartridge bank switcher: single-port synchronous memory.
// Depends on cbs_pkg for the default depth.
module cbs_rom #(
    parameter int ROM_BYTES = cbs_pkg::ROM_BYTES_DEF,
    localparam int AW = $clog2(ROM_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    import cbs_pkg::*;

    logic [7:0] r_mem [ROM_BYTES];
    logic [7:0] r_q;

    assign o_rdata = r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

endmodule

>>> src/cbs_xram.sv
// Extra cartridge RAM: synchronous memory with one valid bit per entry.
// An entry not written since reset reads as zero. Depends on cbs_pkg.
module cbs_xram #(
    parameter int RAM_BYTES = cbs_pkg::RAM_BYTES_DEF,
    localparam int AW = $clog2(RAM_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    import cbs_pkg::*;

    logic [7:0]           r_mem [RAM_BYTES];
    logic [RAM_BYTES-1:0] r_valid;
    logic [7:0]           r_q;
    logic                 r_q_valid;

    assign o_rdata = r_q_valid ? r_q : 8'd0;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            r_q_valid <= r_valid[i_addr];
        end
    end

endmodule

>>> src/cartridge_bank_switcher.sv
// Top level of the cartridge bank switcher: decode, bank register and result select.
// Depends on cbs_pkg, cbs_cfg_regs, cbs_rom and cbs_xram.
// A result appears in the cycle after its item is accepted, set by the memory read.
// One item is accepted per cycle; busy stays low and the receiver cannot stall.
// Reset clears the bank, the configuration and the extra RAM valid bits at once;
// the ROM store keeps its contents.
module cartridge_bank_switcher #(
    parameter int ROM_BYTES  = cbs_pkg::ROM_BYTES_DEF,
    parameter int BANK_BYTES = cbs_pkg::BANK_BYTES_DEF,
    parameter int RAM_BYTES  = cbs_pkg::RAM_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_mode,
    input  logic [15:0]                 i_bus_address,
    input  logic [14:0]                 i_load_index,
    input  logic [7:0]                  i_data_in,
    output logic [7:0]                  o_read_data,
    output logic                        o_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbs_pkg::CFG_AW-1:0]  paddr,
    input  logic [cbs_pkg::CFG_DW-1:0]  pwdata,
    output logic [cbs_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import cbs_pkg::*;

    localparam int RAW = $clog2(ROM_BYTES);
    localparam int XAW = $clog2(RAM_BYTES);
    localparam int BW  = $clog2(BANK_BYTES);
    localparam int PW  = 18;
    localparam logic [PW-1:0] C_ROM = PW'(ROM_BYTES);

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_ROM  = 2'd1,
        SRC_XRAM = 2'd2
    } t_src;

    t_cfg       w_cfg;
    t_mode      w_mode;
    logic       w_acc;
    logic [11:0] w_off;
    logic       w_xram_rd;
    logic       w_xram_wr;
    logic       w_hot_en;
    logic [2:0] r_bank;
    logic [2:0] n_bank;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_wrap;
    logic [RAW-1:0] w_rom_addr;
    logic       w_rom_we;
    logic [7:0] w_rom_q;
    logic [7:0] w_xram_q;
    t_src       r_src;
    t_src       n_src;
    logic       r_done;

    cbs_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign busy      = 1'b0;
    assign w_acc     = start && !busy;
    assign w_mode    = t_mode'(i_mode);
    assign w_off     = i_bus_address[11:0];
    assign w_xram_rd = w_cfg.xram_en && (w_off >= XRAM_RD_LO) && (w_off < XRAM_RD_HI);
    assign w_xram_wr = w_cfg.xram_en && (w_off < XRAM_WR_HI);
    assign w_hot_en  = w_acc && (((w_mode == MODE_READ) && !w_xram_rd) ||
                                 ((w_mode == MODE_WRITE) && !w_xram_wr));

    always_comb begin
        n_bank = r_bank;
        if (w_hot_en) begin
            case (w_cfg.bank_mode)
                BANK_F8: begin
                    if (w_off == HOT_F8_LO) begin
                        n_bank = 3'd0;
                    end else if (w_off == HOT_F8_HI) begin
                        n_bank = 3'd1;
                    end
                end
                BANK_F6: begin
                    if (w_off >= HOT_F6_LO && w_off <= HOT_F8_HI) begin
                        n_bank = 3'(w_off - HOT_F6_LO);
                    end
                end
                BANK_F4: begin
                    if (w_off >= HOT_F4_LO && w_off <= HOT_F4_HI) begin
                        n_bank = 3'(w_off - HOT_F4_LO);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (w_cfg.bank_mode == BANK_NONE) begin
            w_pos = PW'(w_off & (w_cfg.small_rom ? MASK_2K : MASK_4K));
        end else begin
            w_pos = (PW'(n_bank) << BW) + PW'(w_off);
        end
    end

    // The position stays below eight times the ROM size, so three
    // conditional subtractions bring it into range.
    always_comb begin
        w_wrap = w_pos;
        for (int i = 2; i >= 0; i--) begin
            if (w_wrap >= (C_ROM << i)) begin
                w_wrap = w_wrap - (C_ROM << i);
            end
        end
    end

    assign w_rom_we   = w_acc && (w_mode == MODE_LOAD) && (PW'(i_load_index) < C_ROM);
    assign w_rom_addr = (w_mode == MODE_LOAD) ? RAW'(i_load_index) : w_wrap[RAW-1:0];

    cbs_rom #(.ROM_BYTES(ROM_BYTES)) u_rom (
        .i_clk   (i_clk),
        .i_we    (w_rom_we),
        .i_addr  (w_rom_addr),
        .i_wdata (i_data_in),
        .o_rdata (w_rom_q)
    );

    cbs_xram #(.RAM_BYTES(RAM_BYTES)) u_xram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_acc && (w_mode == MODE_WRITE) && w_xram_wr),
        .i_addr  (w_off[XAW-1:0] & XRAM_MASK[XAW-1:0]),
        .i_wdata (i_data_in),
        .o_rdata (w_xram_q)
    );

    always_comb begin
        n_src = SRC_ZERO;
        if (w_mode == MODE_READ) begin
            n_src = w_xram_rd ? SRC_XRAM : SRC_ROM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 3'd0;
            r_done <= 1'b0;
            r_src  <= SRC_ZERO;
        end else begin
            r_bank <= n_bank;
            r_done <= w_acc;
            if (w_acc) begin
                r_src <= n_src;
            end
        end
    end

    assign o_done = r_done;

    always_comb begin
        case (r_src)
            SRC_ROM:  o_read_data = w_rom_q;
            SRC_XRAM: o_read_data = w_xram_q;
            default:  o_read_data = 8'd0;
        endcase
    end

endmodule

>>> verif/testbench.sv
// Testbench for the cartridge bank switcher: queued bus, load and unused items with
// random gaps, checked one by one against an in-bench prediction of bank and memories.
// Depends on cbs_pkg and cartridge_bank_switcher.
module testbench;
    import cbs_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] addr;
        logic [14:0] idx;
        logic [7:0]  data;
    } t_access;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_mode = MODE_NONE;
    logic [15:0]         i_bus_address = '0;
    logic [14:0]         i_load_index = '0;
    logic [7:0]          i_data_in = '0;
    logic [7:0]          o_read_data;
    logic                o_done;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    cartridge_bank_switcher u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_bus_address(i_bus_address), .i_load_index(i_load_index),
        .i_data_in(i_data_in), .o_read_data(o_read_data), .o_done(o_done),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_access     pending_items[$];
    logic [7:0]  expected_read_data[$];
    t_access     cur_item = '0;
    bit          holding = 1'b0;
    bit          took = 1'b0;
    bit          no_idle = 1'b0;
    int          errors = 0;
    int          cycles = 0;

    t_cfg        cfg_now = '0;
    logic [2:0]  pred_bank = '0;
    logic [7:0]  pred_xram [RAM_BYTES_DEF];
    logic [7:0]  pred_rom [ROM_BYTES_DEF];
    logic [2:0]  plan_bank = '0;
    bit          plan_loaded [ROM_BYTES_DEF];

    initial begin
        foreach (pred_xram[i]) pred_xram[i] = '0;
    end

    function automatic logic [2:0] bank_after(t_cfg c, logic [2:0] bank, logic [11:0] off);
        logic [11:0] d;
        case (c.bank_mode)
            BANK_F8: begin
                if (off == HOT_F8_LO) bank = 3'd0;
                else if (off == HOT_F8_HI) bank = 3'd1;
            end
            BANK_F6: begin
                if (off >= HOT_F6_LO && off <= HOT_F8_HI) begin
                    d = off - HOT_F6_LO;
                    bank = d[2:0];
                end
            end
            BANK_F4: begin
                if (off >= HOT_F4_LO && off <= HOT_F4_HI) begin
                    d = off - HOT_F4_LO;
                    bank = d[2:0];
                end
            end
            default: ;
        endcase
        return bank;
    endfunction

    function automatic logic [14:0] rom_pos(t_cfg c, logic [2:0] bank, logic [11:0] off);
        if (c.bank_mode == BANK_NONE)
            return {3'b000, off & (c.small_rom ? MASK_2K : MASK_4K)};
        return {bank, off};
    endfunction

    function automatic bit xram_rd_hit(t_cfg c, logic [11:0] off);
        return c.xram_en && off >= XRAM_RD_LO && off < XRAM_RD_HI;
    endfunction

    function automatic bit xram_wr_hit(t_cfg c, logic [11:0] off);
        return c.xram_en && off < XRAM_WR_HI;
    endfunction

    function automatic logic [7:0] serve_access(t_access it);
        logic [11:0] off;
        logic [7:0]  rd;
        off = it.addr[11:0];
        rd = '0;
        case (it.mode)
            MODE_READ: begin
                if (xram_rd_hit(cfg_now, off)) begin
                    rd = pred_xram[off[6:0]];
                end else begin
                    pred_bank = bank_after(cfg_now, pred_bank, off);
                    rd = pred_rom[rom_pos(cfg_now, pred_bank, off)];
                end
            end
            MODE_WRITE: begin
                if (xram_wr_hit(cfg_now, off)) pred_xram[off[6:0]] = it.data;
                else pred_bank = bank_after(cfg_now, pred_bank, off);
            end
            MODE_LOAD: pred_rom[it.idx] = it.data;
            default: ;
        endcase
        return rd;
    endfunction

    // A read of a ROM byte that was never loaded is preceded by a load of that byte.
    task automatic queue_item(t_mode m, logic [15:0] a, logic [14:0] ix, logic [7:0] d);
        logic [11:0] off;
        logic [2:0]  nb;
        logic [14:0] pos;
        t_access     it;
        off = a[11:0];
        if (m == MODE_READ && !xram_rd_hit(cfg_now, off)) begin
            nb = bank_after(cfg_now, plan_bank, off);
            pos = rom_pos(cfg_now, nb, off);
            if (!plan_loaded[pos]) begin
                it = '{mode: MODE_LOAD, addr: 16'($urandom), idx: pos, data: 8'($urandom)};
                pending_items.push_back(it);
                plan_loaded[pos] = 1'b1;
            end
            plan_bank = nb;
        end else if (m == MODE_WRITE && !xram_wr_hit(cfg_now, off)) begin
            plan_bank = bank_after(cfg_now, plan_bank, off);
        end else if (m == MODE_LOAD) begin
            plan_loaded[ix] = 1'b1;
        end
        it = '{mode: m, addr: a, idx: ix, data: d};
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] pick_address();
        logic [11:0] off;
        case ($urandom_range(3))
            0: off = 12'hFF0 | 12'($urandom_range(15));
            1: off = 12'($urandom_range(511));
            default: off = 12'($urandom);
        endcase
        return {4'($urandom), off};
    endfunction

    task automatic queue_random(int n);
        int          cnt;
        int          k;
        int          r;
        t_mode       m;
        logic [14:0] ix;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(7) == 0) begin
                k = $urandom_range(6, 2);
                queue_item($urandom_range(1) ? MODE_WRITE : MODE_READ,
                           {4'($urandom), 12'hFF4 + 12'($urandom_range(7))},
                           15'($urandom), 8'($urandom));
                repeat (k) queue_item(MODE_READ, pick_address(), 15'($urandom), 8'($urandom));
                cnt += k + 1;
            end else begin
                r = $urandom_range(99);
                if (r < 40) m = MODE_READ;
                else if (r < 60) m = MODE_WRITE;
                else if (r < 94) m = MODE_LOAD;
                else m = MODE_NONE;
                ix = $urandom_range(1) ? {plan_bank, 12'($urandom)} : 15'($urandom);
                queue_item(m, pick_address(), ix, 8'($urandom));
                if (m != MODE_NONE) cnt++;
            end
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || holding || expected_read_data.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx r, logic [CFG_DW-1:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== v) begin
            $error("register %s expected %0h got %0h", r.name(), v, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_cfg(t_bank_mode bm, logic small_rom, logic xram);
        drain();
        cfg_write(REG_BANK_MODE, CFG_DW'(bm));
        cfg_write(REG_SMALL_ROM, CFG_DW'(small_rom));
        cfg_write(REG_XRAM_EN, CFG_DW'(xram));
        cfg_now = '{bank_mode: bm, small_rom: small_rom, xram_en: xram};
    endtask

    always @(negedge i_clk) begin
        if (took) begin
            took = 1'b0;
            holding = 1'b0;
        end
        if (!holding && pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
            cur_item = pending_items.pop_front();
            holding = 1'b1;
        end
        start <= holding;
        i_mode <= cur_item.mode;
        i_bus_address <= cur_item.addr;
        i_load_index <= cur_item.idx;
        i_data_in <= cur_item.data;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (expected_read_data.size() == 0) begin
                $error("read_data expected none got %0h", o_read_data);
                errors++;
            end else if (o_read_data !== expected_read_data[0]) begin
                $error("read_data expected %0h got %0h", expected_read_data[0], o_read_data);
                errors++;
                void'(expected_read_data.pop_front());
            end else begin
                void'(expected_read_data.pop_front());
            end
        end
        if (i_rst_n && start && !busy) begin
            expected_read_data.push_back(serve_access(cur_item));
            took = 1'b1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(MODE_LOAD, 16'h0000, 15'h0000, 8'h00);
        queue_item(MODE_LOAD, 16'hFFFF, 15'h7FFF, 8'hFF);
        queue_item(MODE_READ, 16'h0000, 15'h0000, 8'h00);
        queue_item(MODE_READ, 16'hF000, 15'h7FFF, 8'hFF);
        queue_item(MODE_READ, 16'hFFFF, 15'h0000, 8'h00);
        queue_item(MODE_WRITE, 16'hFFF9, 15'h0000, 8'hFF);
        queue_item(MODE_NONE, 16'hFFFF, 15'h7FFF, 8'hFF);
        queue_random(50);

        set_cfg(BANK_NONE, 1'b1, 1'b1);
        queue_item(MODE_READ, 16'h00FF, 15'h0000, 8'h00);
        queue_item(MODE_WRITE, 16'h0000, 15'h0000, 8'hA5);
        queue_item(MODE_WRITE, 16'h007F, 15'h0000, 8'h5A);
        queue_item(MODE_READ, 16'h0080, 15'h0000, 8'h00);
        queue_item(MODE_READ, 16'h0100, 15'h0000, 8'h00);
        queue_item(MODE_READ, 16'h0FFF, 15'h0000, 8'h00);
        queue_random(50);

        set_cfg(BANK_F8, 1'b0, 1'b0);
        queue_item(MODE_READ, 16'h1FF9, 15'h0000, 8'h00);
        queue_item(MODE_READ, 16'h0FF8, 15'h0000, 8'h00);
        queue_item(MODE_WRITE, 16'h0FF9, 15'h0000, 8'h00);
        queue_item(MODE_READ, 16'h0000, 15'h0000, 8'h00);
        queue_random(60);

        set_cfg(BANK_F6, 1'b1, 1'b1);
        no_idle = 1'b1;
        queue_item(MODE_WRITE, 16'h0FF6, 15'h0000, 8'h00);
        queue_item(MODE_READ, 16'h0FF9, 15'h0000, 8'h00);
        queue_item(MODE_READ, 16'h0080, 15'h0000, 8'h00);
        queue_random(60);
        drain();
        no_idle = 1'b0;

        set_cfg(BANK_F4, 1'b0, 1'b1);
        queue_item(MODE_READ, 16'h0FF4, 15'h0000, 8'h00);
        queue_item(MODE_WRITE, 16'h0FFB, 15'h0000, 8'h00);
        queue_random(80);
        queue_item(MODE_READ, 16'h0FFB, 15'h0000, 8'h00);

        // The bank selected under F4 is kept across the change of mode.
        set_cfg(BANK_F8, 1'b1, 1'b0);
        queue_item(MODE_READ, 16'h0123, 15'h0000, 8'h00);
        queue_random(60);

        set_cfg(BANK_F4, 1'b1, 1'b1);
        queue_random(60);

        set_cfg(BANK_NONE, 1'b0, 1'b1);
        queue_random(50);

        drain();
        repeat (3) @(posedge i_clk);
        if (expected_read_data.size() != 0) begin
            $error("read_data expected %0h got none", expected_read_data[0]);
            errors++;
        end
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
